[rtl/shl_pkg.sv]
// shared types, character codes and keyword table for the span lexer
package shl_pkg;

    localparam int CODE_BITS  = 16;
    localparam int START_BITS = 20;
    localparam int END_BITS   = 21;
    localparam int WORD_BITS  = 63;
    localparam int FIFO_DEPTH = 4;
    localparam int KW_COUNT   = 19;

    localparam logic [3:0] WORD_MAX = 4'd9;

    localparam logic [1:0] MODE_C    = 2'd1;
    localparam logic [1:0] MODE_HTML = 2'd2;

    localparam logic [1:0] CLS_COMMENT = 2'd0;
    localparam logic [1:0] CLS_STRING  = 2'd1;
    localparam logic [1:0] CLS_TAG     = 2'd2;
    localparam logic [1:0] CLS_KEYWORD = 2'd3;

    localparam logic [15:0] CH_SLASH      = 16'h002F;
    localparam logic [15:0] CH_STAR       = 16'h002A;
    localparam logic [15:0] CH_QUOTE      = 16'h0022;
    localparam logic [15:0] CH_BACKSLASH  = 16'h005C;
    localparam logic [15:0] CH_LT         = 16'h003C;
    localparam logic [15:0] CH_GT         = 16'h003E;
    localparam logic [15:0] CH_NEWLINE    = 16'h000A;
    localparam logic [15:0] CH_UNDERSCORE = 16'h005F;

    typedef enum logic [3:0] {
        SC_IDLE,
        SC_SLASH,
        SC_LINE,
        SC_BLOCK,
        SC_BSTAR,
        SC_STR,
        SC_ESC,
        SC_TAG,
        SC_WORD
    } t_scan;

    typedef struct packed {
        logic [CODE_BITS-1:0] code_unit;
        logic                 end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [START_BITS-1:0] span_start;
        logic [END_BITS-1:0]   span_end;
        logic [1:0]            span_class;
        logic                  last_of_run;
    } t_out_item;

    // spans produced by one accepted character, in order
    typedef struct packed {
        logic [1:0] count;
        t_out_item  span0;
        t_out_item  span1;
    } t_spans;

    localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
        "int", "float", "double", "char", "if", "else", "for", "while", "return",
        "void", "class", "struct", "public", "private", "protected", "include",
        "using", "namespace", "std"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd5, 4'd6, 4'd4, 4'd2, 4'd4, 4'd3, 4'd5, 4'd6,
        4'd4, 4'd5, 4'd6, 4'd6, 4'd7, 4'd9, 4'd7,
        4'd5, 4'd9, 4'd3
    };

    function automatic logic is_alpha(input logic [CODE_BITS-1:0] c);
        return (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A);
    endfunction

    function automatic logic is_ident(input logic [CODE_BITS-1:0] c);
        return is_alpha(c) || (c >= 16'h0030 && c <= 16'h0039) || c == CH_UNDERSCORE;
    endfunction

    // first character in the low seven bits
    function automatic logic [WORD_BITS-1:0] kw_pack(input logic [71:0] s,
                                                     input logic [3:0] n);
        logic [WORD_BITS-1:0] w;
        w = '0;
        for (int i = 0; i < 9; i++) begin
            if (i < int'(n)) begin
                w[7*i +: 7] = s[8*(int'(n)-1-i) +: 7];
            end
        end
        return w;
    endfunction

    // unused high bits of the word are always zero
    function automatic logic kw_match(input logic [WORD_BITS-1:0] word,
                                      input logic [3:0] len);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (len == KW_LEN[k] && word == kw_pack(KW_TEXT[k], KW_LEN[k])) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

[rtl/shl_scanner.sv]
// character scanner: scan state, position count and span generation
module shl_scanner #(
    parameter int POSITION_BITS = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  shl_pkg::t_in_item i_item,
    input  logic [1:0]        i_mode,
    output shl_pkg::t_spans   o_spans
);
    import shl_pkg::*;

    localparam int PB = POSITION_BITS;

    t_scan                r_state, n_state, sw_state, st_state;
    logic [PB:0]          r_pos, n_pos, endp1;
    logic [PB-1:0]        r_open, n_open, sw_open, start_clamp;
    logic [WORD_BITS-1:0] r_word, n_word, sw_word, add_word;
    logic [3:0]           r_len, n_len, sw_len, add_len;

    logic [CODE_BITS-1:0] c;
    logic                 eot;
    logic                 mode_on;
    logic                 take_start;

    logic                 a_v, b_v;
    logic [PB:0]          a_end;
    logic [1:0]           a_cls, b_cls;
    logic [31:0]          a_start_ext, b_start_ext, a_end_ext, b_end_ext;
    t_out_item            span_a, span_b;

    assign c       = i_item.code_unit;
    assign eot     = i_item.end_of_text;
    assign mode_on = (i_mode == MODE_C) || (i_mode == MODE_HTML);

    // position saturates at the limit, which is the only value with the top bit set
    assign endp1       = r_pos[PB] ? r_pos : r_pos + 1'b1;
    assign start_clamp = r_pos[PB] ? {PB{1'b1}} : r_pos[PB-1:0];

    // which construct a character opens under the current language rules
    always_comb begin
        st_state = SC_IDLE;
        if (i_mode == MODE_C) begin
            if (c == CH_SLASH) begin
                st_state = SC_SLASH;
            end else if (c == CH_QUOTE) begin
                st_state = SC_STR;
            end else if (is_alpha(c) || c == CH_UNDERSCORE) begin
                st_state = SC_WORD;
            end
        end else if (i_mode == MODE_HTML) begin
            if (c == CH_QUOTE) begin
                st_state = SC_STR;
            end else if (c == CH_LT) begin
                st_state = SC_TAG;
            end
        end
    end

    always_comb begin
        if (r_len < WORD_MAX) begin
            add_word = r_word | (WORD_BITS'(c[6:0]) << (7 * r_len));
            add_len  = r_len + 4'd1;
        end else begin
            add_word = r_word;
            add_len  = WORD_MAX + 4'd1;
        end
    end

    // next state
    always_comb begin
        sw_state   = r_state;
        sw_word    = r_word;
        sw_len     = r_len;
        sw_open    = r_open;
        take_start = 1'b0;
        if (!mode_on) begin
            sw_state = SC_IDLE;
            sw_word  = '0;
            sw_len   = '0;
        end else begin
            case (r_state)
                SC_SLASH: begin
                    if (c == CH_SLASH) begin
                        sw_state = SC_LINE;
                    end else if (c == CH_STAR) begin
                        sw_state = SC_BLOCK;
                    end else begin
                        take_start = 1'b1;
                    end
                end
                SC_LINE: begin
                    if (c == CH_NEWLINE) sw_state = SC_IDLE;
                end
                SC_BLOCK: begin
                    if (c == CH_STAR) sw_state = SC_BSTAR;
                end
                SC_BSTAR: begin
                    if (c == CH_SLASH) begin
                        sw_state = SC_IDLE;
                    end else if (c != CH_STAR) begin
                        sw_state = SC_BLOCK;
                    end
                end
                SC_STR: begin
                    if (c == CH_BACKSLASH) begin
                        sw_state = SC_ESC;
                    end else if (c == CH_QUOTE) begin
                        sw_state = SC_IDLE;
                    end
                end
                SC_ESC: begin
                    sw_state = SC_STR;
                end
                SC_TAG: begin
                    if (c == CH_GT) sw_state = SC_IDLE;
                end
                SC_WORD: begin
                    if (is_ident(c)) begin
                        sw_word = add_word;
                        sw_len  = add_len;
                    end else begin
                        take_start = 1'b1;
                    end
                end
                default: begin
                    take_start = 1'b1;
                end
            endcase
        end
        if (take_start) begin
            sw_state = st_state;
            if (st_state == SC_WORD) begin
                sw_word = {{(WORD_BITS-7){1'b0}}, c[6:0]};
                sw_len  = 4'd1;
            end
            if (st_state != SC_IDLE) sw_open = start_clamp;
        end

        if (eot) begin
            n_state = SC_IDLE;
            n_pos   = '0;
            n_open  = '0;
            n_word  = '0;
            n_len   = '0;
        end else begin
            n_state = sw_state;
            n_pos   = endp1;
            n_open  = sw_open;
            n_word  = sw_word;
            n_len   = sw_len;
        end
    end

    // spans closed by this character, then the one closed by end of text
    always_comb begin
        a_v   = 1'b0;
        a_end = endp1;
        a_cls = CLS_COMMENT;
        if (mode_on) begin
            case (r_state)
                SC_LINE: begin
                    a_v   = (c == CH_NEWLINE);
                    a_end = r_pos;
                end
                SC_BSTAR: begin
                    a_v = (c == CH_SLASH);
                end
                SC_STR: begin
                    a_v   = (c == CH_QUOTE);
                    a_cls = CLS_STRING;
                end
                SC_TAG: begin
                    a_v   = (c == CH_GT);
                    a_cls = CLS_TAG;
                end
                SC_WORD: begin
                    a_v   = !is_ident(c) && kw_match(r_word, r_len);
                    a_end = r_pos;
                    a_cls = CLS_KEYWORD;
                end
                default: begin
                    a_v = 1'b0;
                end
            endcase
        end

        b_v   = 1'b0;
        b_cls = CLS_COMMENT;
        if (eot) begin
            case (sw_state)
                SC_LINE, SC_BLOCK, SC_BSTAR: begin
                    b_v = 1'b1;
                end
                SC_STR, SC_ESC: begin
                    b_v   = 1'b1;
                    b_cls = CLS_STRING;
                end
                SC_TAG: begin
                    b_v   = 1'b1;
                    b_cls = CLS_TAG;
                end
                SC_WORD: begin
                    b_v   = kw_match(sw_word, sw_len);
                    b_cls = CLS_KEYWORD;
                end
                default: begin
                    b_v = 1'b0;
                end
            endcase
        end

        a_start_ext = 32'(r_open);
        b_start_ext = 32'(sw_open);
        a_end_ext   = 32'(a_end);
        b_end_ext   = 32'(endp1);

        span_a.span_start  = a_start_ext[START_BITS-1:0];
        span_a.span_end    = a_end_ext[END_BITS-1:0];
        span_a.span_class  = a_cls;
        span_a.last_of_run = !b_v;

        span_b.span_start  = b_start_ext[START_BITS-1:0];
        span_b.span_end    = b_end_ext[END_BITS-1:0];
        span_b.span_class  = b_cls;
        span_b.last_of_run = 1'b1;

        o_spans.count = {1'b0, a_v} + {1'b0, b_v};
        o_spans.span0 = a_v ? span_a : span_b;
        o_spans.span1 = span_b;
        if (!i_accept) o_spans.count = 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_pos   <= '0;
            r_open  <= '0;
            r_word  <= '0;
            r_len   <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_open  <= n_open;
            r_word  <= n_word;
            r_len   <= n_len;
        end
    end

endmodule

[rtl/shl_span_fifo.sv]
// span queue: up to two writes and one read per cycle
module shl_span_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  shl_pkg::t_spans    i_spans,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_stall,
    output shl_pkg::t_out_item o_item
);
    import shl_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    t_out_item     r_mem [FIFO_DEPTH];
    logic [AW-1:0] r_rd, r_wr, n_rd, n_wr;
    logic [AW:0]   r_cnt, n_cnt;
    logic          pop;

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;
    // room for the worst case of two spans from one character
    assign o_room  = (r_cnt <= (AW+1)'(FIFO_DEPTH - 2));

    always_comb begin
        n_wr  = r_wr + AW'(i_spans.count);
        n_rd  = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (AW+1)'(i_spans.count) - (AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_spans.count != 2'd0) r_mem[r_wr] <= i_spans.span0;
        if (i_spans.count == 2'd2) r_mem[r_wr + 1'b1] <= i_spans.span1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end

endmodule

[rtl/syntax_highlight_span_lexer_core.sv]
// span lexer top level: mode register, scanner and span queue
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_stall     i_in_item (code unit, end of text)
//  result    out        o_out_valid / i_out_stall   o_out_item (start, end, class, last)
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_data (language mode)
//
// one character is taken per cycle unless input stalls; its spans are queued next cycle
// a character closes at most two spans, the queue drains one span per unstalled cycle
// input stalls while the four-entry span queue has fewer than two free slots
// reset returns the scanner to idle at position zero and the mode to no highlighting
module syntax_highlight_span_lexer_core #(
    parameter int POSITION_BITS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  shl_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output shl_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_data
);
    import shl_pkg::*;

    logic [1:0] r_mode;
    logic       accept;
    logic       room;
    t_spans     spans;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !room;
    assign accept      = i_in_valid && room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    shl_scanner #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scanner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .i_mode   (r_mode),
        .o_spans  (spans)
    );

    shl_span_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_spans (spans),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

[bench/testbench.sv]
// testbench for the span lexer: directed texts, mode switch, random texts and backpressure
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import shl_pkg::*;

    localparam int          POS_BITS    = 20;
    localparam int unsigned POS_LIM     = 1 << POS_BITS;
    localparam int          CYCLE_LIMIT = 4_000_000;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    logic       i_clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_item = '0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [1:0] cfg_data = 2'd0;

    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_item;
    logic       o_cfg_ready;

    syntax_highlight_span_lexer_core #(
        .POSITION_BITS(POS_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    string kw_list [19] = '{
        "int", "float", "double", "char", "if", "else", "for", "while", "return",
        "void", "class", "struct", "public", "private", "protected", "include",
        "using", "namespace", "std"
    };
    string id_chars = "_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";

    // lexer state as the block should hold it
    logic [1:0]     hl_mode = MODE_NONE;
    t_scan          scan_st = SC_IDLE;
    int unsigned    text_pos = 0;
    int unsigned    open_start = 0;
    logic [62:0]    word_bits = '0;
    int             word_len = 0;
    int             spans_now = 0;

    t_out_item      span_q [$];
    logic [15:0]    text_q [$];
    t_out_item      want;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int err_cnt = 0;
    int cycle_cnt = 0;

    function automatic void put_code(logic [15:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    function automatic bit is_letter(logic [15:0] c);
        return (c >= 16'h41 && c <= 16'h5A) || (c >= 16'h61 && c <= 16'h7A);
    endfunction

    function automatic bit is_word_char(logic [15:0] c);
        return is_letter(c) || (c >= 16'h30 && c <= 16'h39) || c == CH_UNDERSCORE;
    endfunction

    function automatic int unsigned cap_end(int unsigned v);
        return (v < POS_LIM) ? v : POS_LIM;
    endfunction

    // nine characters are kept, a tenth marks the word as too long
    function automatic void word_push(logic [15:0] c);
        if (word_len < 9) begin
            word_bits[7*word_len +: 7] = c[6:0];
            word_len++;
        end else begin
            word_len = 10;
        end
    endfunction

    function automatic bit word_is_kw();
        bit hit, same;
        hit = 1'b0;
        for (int k = 0; k < 19; k++) begin
            same = (kw_list[k].len() == word_len);
            for (int i = 0; i < word_len && i < 9; i++) begin
                if (same && {1'b0, word_bits[7*i +: 7]} != kw_list[k][i]) same = 1'b0;
            end
            hit |= same;
        end
        return hit;
    endfunction

    function automatic void add_span(int unsigned s, int unsigned e, logic [1:0] cls);
        t_out_item it;
        it.span_start  = s[START_BITS-1:0];
        it.span_end    = e[END_BITS-1:0];
        it.span_class  = cls;
        it.last_of_run = 1'b0;
        span_q.insert(span_q.size(), it);
        spans_now++;
    endfunction

    // the mode only decides which construct may open here
    function automatic void open_construct(logic [15:0] c, int unsigned p);
        scan_st = SC_IDLE;
        if (hl_mode == MODE_C) begin
            if (c == CH_SLASH) scan_st = SC_SLASH;
            else if (c == CH_QUOTE) scan_st = SC_STR;
            else if (is_letter(c) || c == CH_UNDERSCORE) begin
                scan_st   = SC_WORD;
                word_bits = '0;
                word_len  = 0;
                word_push(c);
            end
        end else if (hl_mode == MODE_HTML) begin
            if (c == CH_QUOTE) scan_st = SC_STR;
            else if (c == CH_LT) scan_st = SC_TAG;
        end
        if (scan_st != SC_IDLE) open_start = (p < POS_LIM) ? p : POS_LIM - 1;
    endfunction

    function automatic void lex_char(logic [15:0] c, logic eot);
        int unsigned p, ep;
        p = text_pos;
        spans_now = 0;
        if (hl_mode != MODE_C && hl_mode != MODE_HTML) begin
            scan_st   = SC_IDLE;
            word_len  = 0;
            word_bits = '0;
        end else begin
            case (scan_st)
                SC_SLASH: begin
                    if (c == CH_SLASH) scan_st = SC_LINE;
                    else if (c == CH_STAR) scan_st = SC_BLOCK;
                    else open_construct(c, p);
                end
                SC_LINE: begin
                    if (c == CH_NEWLINE) begin
                        add_span(open_start, cap_end(p), CLS_COMMENT);
                        scan_st = SC_IDLE;
                    end
                end
                SC_BLOCK: begin
                    if (c == CH_STAR) scan_st = SC_BSTAR;
                end
                SC_BSTAR: begin
                    if (c == CH_SLASH) begin
                        add_span(open_start, cap_end(p + 1), CLS_COMMENT);
                        scan_st = SC_IDLE;
                    end else if (c != CH_STAR) begin
                        scan_st = SC_BLOCK;
                    end
                end
                SC_STR: begin
                    if (c == CH_BACKSLASH) scan_st = SC_ESC;
                    else if (c == CH_QUOTE) begin
                        add_span(open_start, cap_end(p + 1), CLS_STRING);
                        scan_st = SC_IDLE;
                    end
                end
                SC_ESC: scan_st = SC_STR;
                SC_TAG: begin
                    if (c == CH_GT) begin
                        add_span(open_start, cap_end(p + 1), CLS_TAG);
                        scan_st = SC_IDLE;
                    end
                end
                SC_WORD: begin
                    if (is_word_char(c)) word_push(c);
                    else begin
                        if (word_is_kw()) add_span(open_start, cap_end(p), CLS_KEYWORD);
                        open_construct(c, p);
                    end
                end
                default: open_construct(c, p);
            endcase
        end

        if (eot) begin
            // a comment, string, tag or keyword still open closes at the text length
            ep = cap_end(p + 1);
            case (scan_st)
                SC_LINE, SC_BLOCK, SC_BSTAR: add_span(open_start, ep, CLS_COMMENT);
                SC_STR, SC_ESC:              add_span(open_start, ep, CLS_STRING);
                SC_TAG:                      add_span(open_start, ep, CLS_TAG);
                SC_WORD: begin
                    if (word_is_kw()) add_span(open_start, ep, CLS_KEYWORD);
                end
                default: ;
            endcase
            scan_st    = SC_IDLE;
            text_pos   = 0;
            open_start = 0;
            word_bits  = '0;
            word_len   = 0;
        end else begin
            text_pos = (p < POS_LIM) ? p + 1 : POS_LIM;
        end

        if (spans_now > 0) span_q[span_q.size() - 1].last_of_run = 1'b1;
    endfunction

    // result side: stall pattern plus a long hold-off set by the backpressure test
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            if (span_q.size() == 0) begin
                $error("unexpected span: start %0d end %0d class %0d", o_out_item.span_start,
                       o_out_item.span_end, o_out_item.span_class);
                err_cnt++;
            end else begin
                want = span_q.pop_front();
                if (o_out_item.span_start !== want.span_start) begin
                    $error("span_start: expected %0d, got %0d", want.span_start,
                           o_out_item.span_start);
                    err_cnt++;
                end
                if (o_out_item.span_end !== want.span_end) begin
                    $error("span_end: expected %0d, got %0d", want.span_end,
                           o_out_item.span_end);
                    err_cnt++;
                end
                if (o_out_item.span_class !== want.span_class) begin
                    $error("span_class: expected %0d, got %0d", want.span_class,
                           o_out_item.span_class);
                    err_cnt++;
                end
                if (o_out_item.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                           o_out_item.last_of_run);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one character transfer; valid stays up into the next call unless a gap is taken
    task automatic send_char(input logic [15:0] c, input logic eot);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= {c, eot};
        do @(posedge i_clk); while (o_in_stall);
        lex_char(c, eot);
        @(negedge i_clk);
    endtask

    task automatic send_text(input bit close_text);
        foreach (text_q[i]) send_char(text_q[i], close_text && i == text_q.size() - 1);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) put_code({8'h00, s[i]});
    endtask

    // mode is only changed once every span is out and the scanner has settled
    task automatic write_mode(input logic [1:0] m);
        in_valid <= 1'b0;
        while (span_q.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        hl_mode = m;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        write_mode(MODE_C);
        // keyword cut by a slash, comments, escaped quote, lone slash
        text_q.delete();
        push_str("for/***/\"\\\"\"/a//\n");
        send_text(1'b1);
        // keyword and open string both close on the last character
        text_q.delete();
        push_str("std\"");
        send_text(1'b1);
        // held slash at end of text is dropped
        text_q = '{16'hFFFF, CH_SLASH};
        send_text(1'b1);
        write_mode(MODE_HTML);
        text_q = '{CH_LT, 16'h0000, CH_GT, CH_QUOTE};
        send_text(1'b1);
        write_mode(MODE_RSVD);
        text_q = '{CH_QUOTE};
        send_text(1'b1);
    endtask

    task automatic test_mode_switch();
        write_mode(MODE_C);
        text_q = '{CH_SLASH, CH_STAR};
        send_text(1'b0);
        // comment opened under c rules keeps going under html rules
        write_mode(MODE_HTML);
        text_q = '{CH_STAR, CH_SLASH, CH_LT};
        send_text(1'b1);
    endtask

    task automatic test_backpressure();
        write_mode(MODE_C);
        @(posedge i_clk);
        hold_left = 80;
        @(negedge i_clk);
        text_q.delete();
        repeat (20) push_str("if ");
        send_text(1'b1);
    endtask

    task automatic add_filler(input int n, input bit with_star);
        for (int i = 0; i < n; i++) begin
            if (with_star && $urandom_range(0, 3) == 0) put_code(CH_STAR);
            else put_code(16'($urandom_range(32, 126)));
        end
    endtask

    task automatic add_token();
        int n;
        case ($urandom_range(0, 9))
            0, 1: push_str(kw_list[$urandom_range(0, 18)]);
            2: begin
                n = $urandom_range(1, 12);
                put_code({8'h00, id_chars[$urandom_range(0, 52)]});
                for (int i = 1; i < n; i++) put_code({8'h00, id_chars[$urandom_range(0, 62)]});
            end
            3: begin
                put_code(CH_QUOTE);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 3) == 0) put_code(CH_BACKSLASH);
                    put_code(16'($urandom_range(32, 126)));
                end
                if ($urandom_range(0, 7) != 0) put_code(CH_QUOTE);
            end
            4: begin
                push_str("//");
                add_filler($urandom_range(0, 6), 1'b0);
                put_code(CH_NEWLINE);
            end
            5: begin
                push_str("/*");
                add_filler($urandom_range(0, 6), 1'b1);
                push_str("*/");
            end
            6: begin
                put_code(CH_LT);
                add_filler($urandom_range(0, 5), 1'b0);
                put_code(CH_GT);
            end
            7: begin
                case ($urandom_range(0, 7))
                    0: put_code(CH_SLASH);
                    1: put_code(CH_STAR);
                    2: put_code(CH_QUOTE);
                    3: put_code(CH_BACKSLASH);
                    4: put_code(CH_LT);
                    5: put_code(CH_GT);
                    6: put_code(CH_NEWLINE);
                    default: put_code(CH_UNDERSCORE);
                endcase
            end
            8: put_code(16'($urandom_range(0, 65535)));
            default: push_str(" ");
        endcase
    endtask

    task automatic test_random();
        int sent, pick;
        int idle_tab [4] = '{0, 63, 0, 28};
        int stall_tab [4] = '{0, 0, 63, 28};
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_tab[ph];
            stall_pct = stall_tab[ph];
            sent = 0;
            while (sent < 140) begin
                if ($urandom_range(0, 2) == 0) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 9) write_mode(MODE_C);
                    else if (pick < 16) write_mode(MODE_HTML);
                    else if (pick < 18) write_mode(MODE_NONE);
                    else write_mode(MODE_RSVD);
                end
                text_q.delete();
                repeat ($urandom_range(1, 10)) add_token();
                send_text($urandom_range(0, 3) != 0);
                sent += text_q.size();
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_mode_switch();
        test_backpressure();
        test_random();
        in_valid <= 1'b0;
        while (span_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (err_cnt == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

endmodule
